// File: hw/rtl/v2a_pkg.sv
// Package for the 2-D vector arithmetic unit: payload structs, codes, widths.
// No dependencies.
package v2a_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int Q_W        = FRAC_BITS + 1;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_LEN  = 3'd3;
  localparam logic [2:0] CMD_NORM = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic [31:0]        result_length;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic [1:0]         status;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic               neg_x;
    logic               neg_y;
  } side_t;

endpackage

// File: hw/rtl/v2a_front.sv
// Front stages: multipliers, add/subtract, scale saturation, sum of squares.
// Depends on v2a_pkg.
module v2a_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  v2a_pkg::in_item_t in_d,
  output logic              out_v,
  output v2a_pkg::side_t    out_side,
  output logic [63:0]       out_sq
);
  import v2a_pkg::*;

  logic               v1_r, v2_r;
  logic [2:0]         cmd1_r;
  logic signed [31:0] ax1_r, ay1_r;
  logic signed [32:0] sx1_r, sy1_r;
  logic signed [63:0] px1_r, py1_r;
  side_t              side2_r, side2_nxt;
  logic [63:0]        sq2_r, sq2_nxt;

  logic signed [31:0] opx, opy;
  logic signed [32:0] sx_nxt, sy_nxt;
  logic signed [63:0] shx, shy;
  logic signed [31:0] satx, saty, sclx, scly;
  logic               ovx, ovy, osx, osy;

  always_comb begin
    opx = (in_d.cmd == CMD_MUL) ? in_d.scale_factor : in_d.first_x;
    opy = (in_d.cmd == CMD_MUL) ? in_d.scale_factor : in_d.first_y;
    if (in_d.cmd == CMD_SUB) begin
      sx_nxt = 33'(in_d.first_x) - 33'(in_d.second_x);
      sy_nxt = 33'(in_d.first_y) - 33'(in_d.second_y);
    end else begin
      sx_nxt = 33'(in_d.first_x) + 33'(in_d.second_x);
      sy_nxt = 33'(in_d.first_y) + 33'(in_d.second_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_d.cmd;
      ax1_r   <= in_d.first_x;
      ay1_r   <= in_d.first_y;
      sx1_r   <= sx_nxt;
      sy1_r   <= sy_nxt;
      px1_r   <= 64'(in_d.first_x) * 64'(opx);
      py1_r   <= 64'(in_d.first_y) * 64'(opy);
      side2_r <= side2_nxt;
      sq2_r   <= sq2_nxt;
    end
  end

  always_comb begin
    osx  = sx1_r[32] != sx1_r[31];
    osy  = sy1_r[32] != sy1_r[31];
    satx = osx ? (sx1_r[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sx1_r[31:0];
    saty = osy ? (sy1_r[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sy1_r[31:0];
    shx  = px1_r >>> FRAC_BITS;
    shy  = py1_r >>> FRAC_BITS;
    ovx  = !((&shx[63:31]) || !(|shx[63:31]));
    ovy  = !((&shy[63:31]) || !(|shy[63:31]));
    sclx = ovx ? (shx[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : shx[31:0];
    scly = ovy ? (shy[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : shy[31:0];

    side2_nxt        = '0;
    side2_nxt.cmd    = cmd1_r;
    side2_nxt.mag_x  = ax1_r[31] ? 32'(-ax1_r) : ax1_r;
    side2_nxt.mag_y  = ay1_r[31] ? 32'(-ay1_r) : ay1_r;
    side2_nxt.neg_x  = ax1_r[31];
    side2_nxt.neg_y  = ay1_r[31];
    side2_nxt.status = ST_OK;
    if (cmd1_r == CMD_ADD || cmd1_r == CMD_SUB) begin
      side2_nxt.res_x  = satx;
      side2_nxt.res_y  = saty;
      side2_nxt.status = (osx || osy) ? ST_SAT : ST_OK;
    end else if (cmd1_r == CMD_MUL) begin
      side2_nxt.res_x  = sclx;
      side2_nxt.res_y  = scly;
      side2_nxt.status = (ovx || ovy) ? ST_SAT : ST_OK;
    end
    sq2_nxt = px1_r + py1_r;
  end

  assign out_v    = v2_r;
  assign out_side = side2_r;
  assign out_sq   = sq2_r;

endmodule

// File: hw/rtl/v2a_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on v2a_pkg.
module v2a_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  v2a_pkg::side_t in_side,
  input  logic [63:0]    in_sq,
  output logic           out_v,
  output v2a_pkg::side_t out_side,
  output logic [31:0]    out_root
);
  import v2a_pkg::*;

  logic        v_r    [SQ_STAGES+1];
  side_t       side_r [SQ_STAGES+1];
  logic [63:0] n_r    [SQ_STAGES+1];
  logic [32:0] rem_r  [SQ_STAGES+1];
  logic [31:0] root_r [SQ_STAGES+1];

  assign v_r[0]    = in_v;
  assign side_r[0] = in_side;
  assign n_r[0]    = in_sq;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [34:0] cur, trial;
    logic        take;

    always_comb begin
      cur   = {rem_r[g], n_r[g][63:62]};
      trial = {1'b0, root_r[g], 2'b01};
      take  = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g+1] <= side_r[g];
        n_r[g+1]    <= {n_r[g][61:0], 2'b00};
        rem_r[g+1]  <= take ? 33'(cur - trial) : cur[32:0];
        root_r[g+1] <= {root_r[g][30:0], take};
      end
    end
  end

  assign out_v    = v_r[SQ_STAGES];
  assign out_side = side_r[SQ_STAGES];
  assign out_root = root_r[SQ_STAGES];

endmodule

// File: hw/rtl/v2a_div.sv
// Pipelined restoring divider for both coordinates, one quotient bit per stage.
// Depends on v2a_pkg.
module v2a_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  v2a_pkg::side_t     in_side,
  input  logic [31:0]        in_root,
  output logic               out_v,
  output v2a_pkg::side_t     out_side,
  output logic [31:0]        out_root,
  output logic [v2a_pkg::Q_W-1:0] out_qx,
  output logic [v2a_pkg::Q_W-1:0] out_qy
);
  import v2a_pkg::*;

  logic           v_r    [DIV_STAGES+1];
  side_t          side_r [DIV_STAGES+1];
  logic [31:0]    root_r [DIV_STAGES+1];
  logic [31:0]    rx_r   [DIV_STAGES+1];
  logic [31:0]    ry_r   [DIV_STAGES+1];
  logic [Q_W-1:0] qx_r   [DIV_STAGES+1];
  logic [Q_W-1:0] qy_r   [DIV_STAGES+1];

  assign v_r[0]    = in_v;
  assign side_r[0] = in_side;
  assign root_r[0] = in_root;
  assign rx_r[0]   = {1'b0, in_side.mag_x[31:1]};
  assign ry_r[0]   = {1'b0, in_side.mag_y[31:1]};
  assign qx_r[0]   = '0;
  assign qy_r[0]   = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] tx, ty;
    logic        bx, by, kx, ky;

    always_comb begin
      bx = (g == 0) ? side_r[g].mag_x[0] : 1'b0;
      by = (g == 0) ? side_r[g].mag_y[0] : 1'b0;
      tx = {rx_r[g], bx};
      ty = {ry_r[g], by};
      kx = tx >= {1'b0, root_r[g]};
      ky = ty >= {1'b0, root_r[g]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g+1] <= side_r[g];
        root_r[g+1] <= root_r[g];
        rx_r[g+1]   <= kx ? 32'(tx - {1'b0, root_r[g]}) : tx[31:0];
        ry_r[g+1]   <= ky ? 32'(ty - {1'b0, root_r[g]}) : ty[31:0];
        qx_r[g+1]   <= Q_W'({qx_r[g], kx});
        qy_r[g+1]   <= Q_W'({qy_r[g], ky});
      end
    end
  end

  assign out_v    = v_r[DIV_STAGES];
  assign out_side = side_r[DIV_STAGES];
  assign out_root = root_r[DIV_STAGES];
  assign out_qx   = qx_r[DIV_STAGES];
  assign out_qy   = qy_r[DIV_STAGES];

endmodule

// File: hw/rtl/vector2d_arith_unit.sv
// Top level of the 2-D vector arithmetic unit: front stages, square root,
// divider and output register. Depends on v2a_pkg and the v2a_* modules.
// Pipeline: 2 front + 32 square root + (FRAC_BITS+1) divider + 1 output
// stages, the same for every command.
// Throughput: one transfer per cycle; the whole pipeline holds while a result stalls.
// Reset: rst_n synchronous active low clears all valid bits; no datapath reset.
module vector2d_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  v2a_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output v2a_pkg::out_item_t out_data
);
  import v2a_pkg::*;

  logic           en;
  logic           f_v, s_v, d_v;
  side_t          f_side, s_side, d_side;
  logic [63:0]    f_sq;
  logic [31:0]    s_root, d_root;
  logic [Q_W-1:0] d_qx, d_qy;
  logic           out_valid_r;
  out_item_t      out_data_r, out_data_nxt;
  logic [31:0]    qx_ext, qy_ext;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  v2a_front u_front (
    .clk, .rst_n, .en, .in_v(in_valid), .in_d(in_data),
    .out_v(f_v), .out_side(f_side), .out_sq(f_sq)
  );

  v2a_sqrt u_sqrt (
    .clk, .rst_n, .en, .in_v(f_v), .in_side(f_side), .in_sq(f_sq),
    .out_v(s_v), .out_side(s_side), .out_root(s_root)
  );

  v2a_div u_div (
    .clk, .rst_n, .en, .in_v(s_v), .in_side(s_side), .in_root(s_root),
    .out_v(d_v), .out_side(d_side), .out_root(d_root), .out_qx(d_qx), .out_qy(d_qy)
  );

  always_comb begin
    qx_ext       = {{(32-Q_W){1'b0}}, d_qx};
    qy_ext       = {{(32-Q_W){1'b0}}, d_qy};
    out_data_nxt = '0;
    unique case (d_side.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        out_data_nxt.result_x = d_side.res_x;
        out_data_nxt.result_y = d_side.res_y;
        out_data_nxt.status   = d_side.status;
      end
      CMD_LEN: begin
        out_data_nxt.result_length = d_root;
      end
      CMD_NORM: begin
        out_data_nxt.result_length = d_root;
        if (d_root == '0) begin
          out_data_nxt.status = ST_ZERO;
        end else begin
          out_data_nxt.result_x = d_side.neg_x ? 32'(-qx_ext) : qx_ext;
          out_data_nxt.result_y = d_side.neg_y ? 32'(-qy_ext) : qy_ext;
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_ZERO |->
      out_data_r.result_x == '0 && out_data_r.result_y == '0 &&
      out_data_r.result_length == '0)
    else $error("zero-length status with nonzero fields");
  a_sat_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_SAT |-> out_data_r.result_length == '0)
    else $error("saturated result carries a length");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status == ST_OK || out_data_r.status == ST_SAT ||
      out_data_r.status == ST_ZERO)
    else $error("undefined status code");
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule
